### hdl/pate_pkg.sv
package pate_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int FIDX_W   = 4;
    localparam int FILL_W   = 5;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_UPDATE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // per-cycle command broadcast to every cell
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_HOLD        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOAD_READ   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LOAD_SEARCH = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SHIFT       = 3'd6;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] read_value;
        logic                    found;
        logic [FIDX_W-1:0]       found_index;
        logic [FILL_W-1:0]       fill_count;
    } rsp_t;

    typedef struct packed {
        logic [CMD_W-1:0]        op;
        logic signed [VAL_W-1:0] value;
    } cell_cmd_t;

endpackage

### hdl/packed_array_table_engine_core.sv
// Packed array table engine: an ordered array of signed 32-bit values with a
// fill count, kept in a row of cells, one entry per cell.
//
// Request channel: drive request and raise start; the request is taken at a
// rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle while result holds the
// answer. The receiver cannot stall; every result must be taken as shown.
//
// Request handling:
//   insert, delete, update, errors, unused actions: result in the cycle after
//   the request, busy stays low, so one request per cycle is taken.
//   read: scan until the entry at position reaches the head; search: scan to
//   the lowest matching index or to fill_count - 1; no scan when empty.
//   Read and search shift a snapshot of the cells toward cell 0, one cell per
//   cycle, and watch the head; busy is high during that scan.
//
// Reset clears the fill count and the control state; entry contents are
// unknown but never visible, since only entries below the fill count are read.
module packed_array_table_engine_core #(
    parameter int CAPACITY = pate_pkg::CAPACITY_DEFAULT,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  pate_pkg::req_t request,
    output logic           done,
    output pate_pkg::rsp_t result
);
    import pate_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] size_reg;
    logic [CNT_W-1:0] size_next;
    logic [CNT_W-1:0] step_reg;
    logic [CNT_W-1:0] step_next;
    logic             read_mode_reg;
    logic             read_mode_next;
    logic             done_reg;
    logic             done_next;
    rsp_t             result_reg;
    rsp_t             result_next;

    cell_cmd_t        cmd;
    logic [CNT_W-1:0] cell_pos;
    logic             accept;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] size_ext;

    logic signed [VAL_W-1:0] entry_w [CAPACITY];
    logic                    hit_w   [CAPACITY];
    logic signed [VAL_W-1:0] data_w  [CAPACITY];

    assign busy     = (state_reg == S_SCAN);
    assign accept   = start && !busy;
    assign pos_ext  = CMP_W'(request.position);
    assign size_ext = CMP_W'(size_reg);
    assign cell_pos = CNT_W'(request.position);

    // Decode the request in idle, or run one step of the head scan.
    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        step_next      = step_reg;
        read_mode_next = read_mode_reg;
        done_next      = 1'b0;
        cmd.op         = CMD_HOLD;
        cmd.value      = request.item_value;

        result_next             = '0;
        result_next.fill_count  = FILL_W'(size_reg);

        if (state_reg == S_SCAN)
        begin
            if (hit_w[0])
            begin
                // head holds the wanted entry: report and return to idle
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (read_mode_reg)
                begin
                    result_next.read_value = data_w[0];
                end
                else
                begin
                    result_next.found       = 1'b1;
                    result_next.found_index = FIDX_W'(step_reg);
                end
            end
            else if (step_reg == size_reg - CNT_W'(1))
            begin
                // last live entry seen without a match
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            else
            begin
                // advance the snapshot one cell toward the head
                cmd.op    = CMD_SHIFT;
                step_next = step_reg + CNT_W'(1);
            end
        end
        else if (accept)
        begin
            case (request.action)
                ACT_INSERT:
                begin
                    done_next = 1'b1;
                    if (pos_ext > size_ext)
                    begin
                        result_next.status = STATUS_RANGE;
                    end
                    else if (size_reg == CAP_COUNT)
                    begin
                        result_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.op                 = CMD_INSERT;
                        size_next              = size_reg + CNT_W'(1);
                        result_next.fill_count = FILL_W'(size_next);
                    end
                end
                ACT_DELETE:
                begin
                    done_next = 1'b1;
                    if (pos_ext >= size_ext)
                    begin
                        result_next.status = STATUS_RANGE;
                    end
                    else
                    begin
                        cmd.op                 = CMD_DELETE;
                        size_next              = size_reg - CNT_W'(1);
                        result_next.fill_count = FILL_W'(size_next);
                    end
                end
                ACT_UPDATE:
                begin
                    done_next = 1'b1;
                    if (pos_ext >= size_ext)
                    begin
                        result_next.status = STATUS_RANGE;
                    end
                    else
                    begin
                        cmd.op = CMD_WRITE;
                    end
                end
                ACT_READ:
                begin
                    if (pos_ext >= size_ext)
                    begin
                        done_next          = 1'b1;
                        result_next.status = STATUS_RANGE;
                    end
                    else
                    begin
                        cmd.op         = CMD_LOAD_READ;
                        state_next     = S_SCAN;
                        step_next      = '0;
                        read_mode_next = 1'b1;
                    end
                end
                ACT_SEARCH:
                begin
                    if (size_reg == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        cmd.op         = CMD_LOAD_SEARCH;
                        state_next     = S_SCAN;
                        step_next      = '0;
                        read_mode_next = 1'b0;
                    end
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end
    end

    // Row of cells: entry i talks to entries i-1 and i+1 only.
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_entry;
        logic signed [VAL_W-1:0] right_entry;
        logic                    right_hit;
        logic signed [VAL_W-1:0] right_data;

        if (gi == 0)
        begin : g_first
            assign left_entry = '0;
        end
        else
        begin : g_inner_left
            assign left_entry = entry_w[gi-1];
        end

        if (gi == CAPACITY - 1)
        begin : g_last
            assign right_entry = '0;
            assign right_hit   = 1'b0;
            assign right_data  = '0;
        end
        else
        begin : g_inner_right
            assign right_entry = entry_w[gi+1];
            assign right_hit   = hit_w[gi+1];
            assign right_data  = data_w[gi+1];
        end

        pate_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (gi)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .pos         (cell_pos),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .right_hit   (right_hit),
            .right_data  (right_data),
            .entry       (entry_w[gi]),
            .hit         (hit_w[gi]),
            .data        (data_w[gi])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= '0;
            step_reg      <= '0;
            read_mode_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            step_reg      <= step_next;
            read_mode_reg <= read_mode_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hdl/pate_cell.sv
module pate_cell #(
    parameter int CAPACITY = pate_pkg::CAPACITY_DEFAULT,
    parameter int INDEX    = 0,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pate_pkg::cell_cmd_t               cmd,
    input  logic [CNT_W-1:0]                  pos,
    input  logic signed [pate_pkg::VAL_W-1:0] left_entry,
    input  logic signed [pate_pkg::VAL_W-1:0] right_entry,
    input  logic                              right_hit,
    input  logic signed [pate_pkg::VAL_W-1:0] right_data,
    output logic signed [pate_pkg::VAL_W-1:0] entry,
    output logic                              hit,
    output logic signed [pate_pkg::VAL_W-1:0] data
);
    import pate_pkg::*;

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

    logic signed [VAL_W-1:0] entry_reg;
    logic signed [VAL_W-1:0] entry_next;
    logic                    hit_reg;
    logic                    hit_next;
    logic signed [VAL_W-1:0] data_reg;
    logic signed [VAL_W-1:0] data_next;

    always_comb
    begin
        entry_next = entry_reg;
        hit_next   = hit_reg;
        data_next  = data_reg;
        case (cmd.op)
            CMD_INSERT:
            begin
                if (MY_INDEX > pos)
                begin
                    entry_next = left_entry;
                end
                else if (MY_INDEX == pos)
                begin
                    entry_next = cmd.value;
                end
            end
            CMD_DELETE:
            begin
                if (MY_INDEX >= pos)
                begin
                    entry_next = right_entry;
                end
            end
            CMD_WRITE:
            begin
                if (MY_INDEX == pos)
                begin
                    entry_next = cmd.value;
                end
            end
            CMD_LOAD_READ:
            begin
                hit_next  = (MY_INDEX == pos);
                data_next = entry_reg;
            end
            CMD_LOAD_SEARCH:
            begin
                hit_next  = (entry_reg == cmd.value);
                data_next = entry_reg;
            end
            CMD_SHIFT:
            begin
                hit_next  = right_hit;
                data_next = right_data;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        data_reg  <= data_next;
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;
    assign data  = data_reg;

endmodule

### hdl/pate_checker.sv
module pate_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input pate_pkg::req_t request,
    input logic           done,
    input pate_pkg::rsp_t result
);
    import pate_pkg::*;

    logic req_seen;
    assign req_seen = (request.action == request.action);

    // a result follows an accepted request or the end of a scan
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)) && req_seen)
        else $error("result without a request");

    // busy only rises from an accepted request
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // a match is only reported on a good status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |-> (result.status == STATUS_OK))
        else $error("found with error status");

    // read data only on a successful read, never with a search match
    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.read_value != 0)) |->
            ((result.status == STATUS_OK) && !result.found))
        else $error("read value on a non-read result");

    // no match means index zero
    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.found_index == '0))
        else $error("index without a match");

endmodule

bind packed_array_table_engine_core pate_checker u_pate_checker (.*);

### sim/pate_result_checker.sv
module pate_result_checker #(
    parameter int CAPACITY = pate_pkg::CAPACITY_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  pate_pkg::req_t request,
    input  logic           done,
    input  pate_pkg::rsp_t result,
    output int             fail_count,
    output int             pending_count,
    output int             checked_count
);
    import pate_pkg::*;

    logic signed [VAL_W-1:0] table_entries [CAPACITY];
    int                      table_fill;
    rsp_t                    expected_results [$];
    int                      fail_total;
    int                      checked_total;

    // Apply one request to the shadow array and return the result it must give.
    function automatic rsp_t apply_table_action(input req_t cmd);
        rsp_t outcome;
        int   pos;
        int   i;
        outcome = '0;
        pos = int'(cmd.position);
        case (cmd.action)
            ACT_INSERT:
            begin
                if (pos > table_fill)
                    outcome.status = STATUS_RANGE;
                else if (table_fill >= CAPACITY)
                    outcome.status = STATUS_FULL;
                else
                begin
                    for (i = table_fill; i > pos; i--)
                        table_entries[i] = table_entries[i - 1];
                    table_entries[pos] = cmd.item_value;
                    table_fill++;
                end
            end
            ACT_DELETE:
            begin
                if (pos >= table_fill)
                    outcome.status = STATUS_RANGE;
                else
                begin
                    for (i = pos; i + 1 < table_fill; i++)
                        table_entries[i] = table_entries[i + 1];
                    table_fill--;
                end
            end
            ACT_UPDATE:
            begin
                if (pos >= table_fill)
                    outcome.status = STATUS_RANGE;
                else
                    table_entries[pos] = cmd.item_value;
            end
            ACT_READ:
            begin
                if (pos >= table_fill)
                    outcome.status = STATUS_RANGE;
                else
                    outcome.read_value = table_entries[pos];
            end
            ACT_SEARCH:
            begin
                for (i = 0; i < table_fill; i++)
                begin
                    if (!outcome.found && table_entries[i] == cmd.item_value)
                    begin
                        outcome.found       = 1'b1;
                        outcome.found_index = i[FIDX_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
        outcome.fill_count = table_fill[FILL_W-1:0];
        return outcome;
    endfunction

    function automatic int count_mismatches(input rsp_t want, input rsp_t got);
        int bad;
        bad = 0;
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            bad++;
        end
        if (got.read_value !== want.read_value)
        begin
            $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
            bad++;
        end
        if (got.found !== want.found)
        begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            bad++;
        end
        if (got.found_index !== want.found_index)
        begin
            $error("found_index: expected %0d, actual %0d", want.found_index, got.found_index);
            bad++;
        end
        if (got.fill_count !== want.fill_count)
        begin
            $error("fill_count: expected %0d, actual %0d", want.fill_count, got.fill_count);
            bad++;
        end
        return bad;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            table_fill    = 0;
            fail_total    = 0;
            checked_total = 0;
        end
        else
        begin
            // retire the oldest expectation before taking a new request
            if (done === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result seen with no request outstanding");
                    fail_total++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (count_mismatches(want, result) != 0)
                        fail_total++;
                    checked_total++;
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                expected_results.push_back(apply_table_action(request));
        end
        fail_count    <= fail_total;
        pending_count <= expected_results.size();
        checked_count <= checked_total;
    end

endmodule

### sim/packed_array_table_engine_core_tb.sv
module packed_array_table_engine_core_tb;
    import pate_pkg::*;

    localparam int CAPACITY       = CAPACITY_DEFAULT;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int PHASE_ITEMS    = 100;
    // longest search scan plus the longest sender gap, taken many times over
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = CAPACITY + 8;

    // action codes the block must treat as no-ops
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_C = 3'd7;

    typedef enum int {PHASE_GROW, PHASE_MIX, PHASE_DRAIN} phase_kind_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    rsp_t result;

    int fail_count;
    int pending_count;
    int checked_count;

    // stimulus bookkeeping: a fill estimate only used to aim positions
    int                      est_fill;
    int                      issued_by_action [8];
    int                      full_events;
    int                      empty_events;
    int                      idle_cycles;
    logic signed [VAL_W-1:0] value_pool [8];

    packed_array_table_engine_core #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    pate_result_checker #(
        .CAPACITY (CAPACITY)
    ) u_result_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .done          (done),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Watchdog: count cycles where neither a request nor a result moves.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired after %0d idle cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Present one request and hold it until the block takes it. Returns in the
    // time step of the accepting edge, so the caller may present the next one
    // right away without dropping start.
    task automatic issue_request(input logic [ACTION_W-1:0] act, input int pos,
                                 input logic signed [VAL_W-1:0] val);
        req_t cmd;
        cmd            = '0;
        cmd.action     = act;
        cmd.position   = pos[POS_W-1:0];
        cmd.item_value = val;
        start   <= 1'b1;
        request <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // track the fill level the same way the block should, to aim positions
        issued_by_action[act]++;
        if (act == ACT_INSERT && cmd.position <= est_fill && est_fill < CAPACITY)
        begin
            est_fill++;
            if (est_fill == CAPACITY)
                full_events++;
        end
        else if (act == ACT_DELETE && cmd.position < est_fill)
        begin
            est_fill--;
            if (est_fill == 0)
                empty_events++;
        end
        if (act == ACT_INSERT || act == ACT_UPDATE)
            value_pool[$urandom_range(0, 7)] = val;
    endtask

    // Drop start for a number of cycles; zero keeps the request stream back to back.
    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(input bit no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Mix fresh words, values already stored (so searches hit and duplicates
    // form), the signed extremes and a narrow band around zero.
    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom();
        else if (r < 7)
            return value_pool[$urandom_range(0, 7)];
        else if (r < 8)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        else
            return $signed($urandom_range(0, 6)) - 3;
    endfunction

    // Weight the action mix by phase: grow toward full, churn, or drain to empty.
    function automatic logic [ACTION_W-1:0] pick_action(input phase_kind_t kind);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return ACTION_W'($urandom_range(ACT_SPARE_A, ACT_SPARE_C));
        r = $urandom_range(0, 99);
        case (kind)
            PHASE_GROW:
            begin
                if (r < 50)      return ACT_INSERT;
                else if (r < 60) return ACT_DELETE;
                else if (r < 70) return ACT_UPDATE;
                else if (r < 85) return ACT_READ;
                else             return ACT_SEARCH;
            end
            PHASE_DRAIN:
            begin
                if (r < 15)      return ACT_INSERT;
                else if (r < 60) return ACT_DELETE;
                else if (r < 70) return ACT_UPDATE;
                else if (r < 85) return ACT_READ;
                else             return ACT_SEARCH;
            end
            default:
            begin
                if (r < 25)      return ACT_INSERT;
                else if (r < 45) return ACT_DELETE;
                else if (r < 60) return ACT_UPDATE;
                else if (r < 80) return ACT_READ;
                else             return ACT_SEARCH;
            end
        endcase
    endfunction

    // Aim most positions at valid entries; leave some to roam the whole field.
    function automatic int pick_position(input logic [ACTION_W-1:0] act);
        if ($urandom_range(0, 99) < 12)
            return $urandom_range(0, (1 << POS_W) - 1);
        else if (act == ACT_INSERT)
            return $urandom_range(0, est_fill);
        else if (est_fill == 0)
            return 0;
        else
            return $urandom_range(0, est_fill - 1);
    endfunction

    initial
    begin
        int                      i;
        int                      phase;
        phase_kind_t             kind;
        bit                      no_idle;
        logic [ACTION_W-1:0]     act;

        rst_n    = 1'b0;
        start    = 1'b0;
        request  = '0;
        est_fill = 0;
        full_events  = 0;
        empty_events = 0;
        idle_cycles  = 0;
        for (i = 0; i < 8; i++)
        begin
            issued_by_action[i] = 0;
            value_pool[i]       = $signed(i) - 4;
        end

        // hold reset, release it once
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-array corner cases first.
        issue_request(ACT_SEARCH, 0, 32'sd5);           // search on empty: not found
        issue_request(ACT_READ,   0, 32'sd0);           // read beyond fill count
        issue_request(ACT_DELETE, 0, 32'sd0);           // delete beyond fill count
        issue_request(ACT_INSERT, 1, 32'sd9);           // insert past the end
        issue_request(ACT_SPARE_C, 31, -32'sd1);        // unused action, all ones
        // Build up with extremes at the front, the end and the middle.
        issue_request(ACT_INSERT, 0, 32'sh7FFF_FFFF);
        issue_request(ACT_INSERT, 0, 32'sh8000_0000);
        issue_request(ACT_INSERT, 2, 32'sd0);
        hold_off(pick_gap(1'b0));
        issue_request(ACT_INSERT, 1, -32'sd1);
        // fill to capacity with repeated values so search must pick the lowest
        for (i = 4; i < CAPACITY; i++)
            issue_request(ACT_INSERT, i / 2, 32'sd100 + (i % 3));
        // bad position is reported ahead of the full condition
        issue_request(ACT_INSERT, 0, 32'sd7);
        issue_request(ACT_INSERT, CAPACITY + 1, 32'sd7);
        issue_request(ACT_SEARCH, 0, 32'sd101);
        issue_request(ACT_SEARCH, 0, 32'sd12345);
        issue_request(ACT_READ, CAPACITY - 1, 32'sd0);
        issue_request(ACT_UPDATE, CAPACITY - 1, 32'sd42);
        issue_request(ACT_DELETE, CAPACITY - 1, 32'sd0);
        issue_request(ACT_DELETE, 0, 32'sd0);
        issue_request(ACT_SPARE_A, 3, 32'sd1);
        issue_request(ACT_SPARE_B, 16, 32'sd2);

        // Pause the sender until the pipe is empty at least once.
        wait_for_results();

        // Random phases: grow, churn, drain in turn, with random content.
        for (phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++)
        begin
            kind    = phase_kind_t'(phase % 3);
            no_idle = ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                act = pick_action(kind);
                issue_request(act, pick_position(act), pick_value());
                hold_off(pick_gap(no_idle));
            end
            if ($urandom_range(0, 1) == 0)
                wait_for_results();
        end

        // Drain, then let any late strobe show up before the verdict.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display({"Run covered %0d inserts, %0d deletes, %0d updates, %0d reads, ",
                  "%0d searches, %0d spare actions."},
                 issued_by_action[ACT_INSERT], issued_by_action[ACT_DELETE],
                 issued_by_action[ACT_UPDATE], issued_by_action[ACT_READ],
                 issued_by_action[ACT_SEARCH],
                 issued_by_action[ACT_SPARE_A] + issued_by_action[ACT_SPARE_B]
                 + issued_by_action[ACT_SPARE_C]);
        $display("Compared %0d results; array reached full %0d times and empty %0d times.",
                 checked_count, full_events, empty_events);
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
hdl/pate_pkg.sv
hdl/pate_cell.sv
hdl/packed_array_table_engine_core.sv
hdl/pate_checker.sv
sim/pate_result_checker.sv
sim/packed_array_table_engine_core_tb.sv
